[hw/rtl/seven_segment_number_serializer_assert.svh]
// Assertion macros for the seven-segment number serializer.
// Included by the top level; no other dependencies.
`ifndef SEVEN_SEGMENT_NUMBER_SERIALIZER_ASSERT_SVH
`define SEVEN_SEGMENT_NUMBER_SERIALIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// consequent must hold in the same cycle as the antecedent
`define SSNS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ssns: same-cycle check failed");
// consequent must hold in the cycle after the antecedent
`define SSNS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ssns: next-cycle check failed");
`else
`define SSNS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SSNS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[hw/rtl/ssns_pkg.sv]
// Shared types, constants and the segment lookup for the number serializer.
// No dependencies.
`default_nettype none
package ssns_pkg;

	localparam logic [3:0] MAX_DIGITS     = 4'd8;
	localparam int         QUEUE_DEPTH    = 2;
	localparam int         QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int         QLVL_W         = $clog2(QUEUE_DEPTH + 1);

	// configuration register indexes
	localparam logic [3:0] REG_DIGIT_BASE   = 4'd0;
	localparam logic [3:0] REG_COMMON_ANODE = 4'd1;

	localparam logic [4:0] BASE_RESET = 5'd10;
	localparam logic [4:0] BASE_MIN   = 5'd2;
	localparam logic [4:0] BASE_MAX   = 5'd16;

	typedef struct packed {
		logic [15:0] value;
		logic [3:0]  digit_count;
	} in_item_t;

	typedef struct packed {
		logic serial_bit;
		logic last_bit;
	} out_item_t;

	// live configuration handed to the front end
	typedef struct packed {
		logic [4:0] digit_base;
		logic       common_anode;
	} cfg_t;

	// one queued digit: final segment byte and whether it closes the request
	typedef struct packed {
		logic [7:0] pattern;
		logic       last;
	} digit_entry_t;

	// common-anode segment patterns, 0-9 then A b C d E F
	function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
		logic [7:0] p;
		case (digit)
			4'h0: p = 8'hC0;
			4'h1: p = 8'hF9;
			4'h2: p = 8'hA4;
			4'h3: p = 8'hB0;
			4'h4: p = 8'h99;
			4'h5: p = 8'h92;
			4'h6: p = 8'h82;
			4'h7: p = 8'hF8;
			4'h8: p = 8'h80;
			4'h9: p = 8'h98;
			4'hA: p = 8'h88;
			4'hB: p = 8'h83;
			4'hC: p = 8'hC6;
			4'hD: p = 8'hA1;
			4'hE: p = 8'h86;
			4'hF: p = 8'h8E;
			default: p = 8'hFF;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

[hw/rtl/ssns_front.sv]
// Front end: accepts requests and splits the value into digits with a
// radix-4 restoring divider. Depends on ssns_pkg.
`default_nettype none
module ssns_front (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ssns_pkg::cfg_t       cfg,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire ssns_pkg::in_item_t   in_item,
	output logic                      push_valid,
	input  wire logic                 push_ready,
	output ssns_pkg::digit_entry_t    push_data
);
	import ssns_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]  state_q;
	logic [15:0] div_q;
	logic [3:0]  rem_q;
	logic [2:0]  step_q;
	logic [3:0]  digits_left_q;
	logic [4:0]  base_q;
	logic        anode_q;

	logic [4:0]  base_eff;
	logic [3:0]  count_eff;
	logic        accept;
	logic [4:0]  t1, t0;
	logic [3:0]  r1, r0;
	logic        q1, q0;

	// clamp base and digit count
	always_comb begin
		if (cfg.digit_base < BASE_MIN) begin
			base_eff = BASE_MIN;
		end else if (cfg.digit_base > BASE_MAX) begin
			base_eff = BASE_MAX;
		end else begin
			base_eff = cfg.digit_base;
		end
		count_eff = (in_item.digit_count > MAX_DIGITS) ? MAX_DIGITS : in_item.digit_count;
	end

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;

	// two restoring steps per cycle, dividend MSBs first
	always_comb begin
		t1 = {rem_q, div_q[15]};
		q1 = (t1 >= base_q);
		r1 = q1 ? 4'(t1 - base_q) : t1[3:0];
		t0 = {r1, div_q[14]};
		q0 = (t0 >= base_q);
		r0 = q0 ? 4'(t0 - base_q) : t0[3:0];
	end

	// digit hand-off to the queue
	assign push_valid        = (state_q == ST_PUSH);
	assign push_data.pattern = seg_pattern(rem_q) ^ {8{~anode_q}};
	assign push_data.last    = (digits_left_q == 4'd1);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			step_q        <= 3'd0;
			digits_left_q <= 4'd0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && count_eff != 4'd0) begin
						state_q       <= ST_DIV;
						step_q        <= 3'd0;
						digits_left_q <= count_eff;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (push_ready) begin
						if (digits_left_q == 4'd1) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_DIV;
						end
						step_q        <= 3'd0;
						digits_left_q <= digits_left_q - 4'd1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath: dividend becomes quotient after eight steps
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			div_q   <= in_item.value;
			rem_q   <= 4'd0;
			base_q  <= base_eff;
			anode_q <= cfg.common_anode;
		end else if (state_q == ST_DIV) begin
			div_q <= {div_q[13:0], q1, q0};
			rem_q <= r0;
		end else if (state_q == ST_PUSH && push_ready) begin
			rem_q <= 4'd0;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/ssns_queue.sv]
// Short queue of segment bytes between front end and serializer.
// Depends on ssns_pkg.
`default_nettype none
module ssns_queue (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    push_valid,
	output logic                         push_ready,
	input  wire ssns_pkg::digit_entry_t  push_data,
	output logic                         pop_valid,
	input  wire logic                    pop_ready,
	output ssns_pkg::digit_entry_t       pop_data
);
	import ssns_pkg::*;

	digit_entry_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QLVL_W-1:0]   level_q;
	logic                do_push, do_pop;

	assign push_ready = (level_q != QLVL_W'(QUEUE_DEPTH));
	assign pop_valid  = (level_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + 1'b1;
			end else if (do_pop && !do_push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

[hw/rtl/ssns_back.sv]
// Back end: shifts each queued segment byte out MSB first through an
// output register. Depends on ssns_pkg.
`default_nettype none
module ssns_back (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    pop_valid,
	output logic                         pop_ready,
	input  wire ssns_pkg::digit_entry_t  pop_data,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output ssns_pkg::out_item_t          out_item
);
	import ssns_pkg::*;

	logic [7:0]  shift_q;
	logic        last_q;
	logic [2:0]  bit_cnt_q;
	logic        busy_q;
	logic        out_valid_q;
	out_item_t   out_item_q;

	logic        out_free;
	logic        load_out;
	logic        byte_done;

	assign out_free  = !out_valid_q || !out_stall;
	assign load_out  = busy_q && out_free;
	assign byte_done = load_out && (bit_cnt_q == 3'd7);
	assign pop_ready = !busy_q || byte_done;

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// shifter control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			bit_cnt_q   <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_valid && pop_ready) begin
				busy_q    <= 1'b1;
				bit_cnt_q <= 3'd0;
			end else if (load_out) begin
				bit_cnt_q <= bit_cnt_q + 3'd1;
				if (byte_done) begin
					busy_q <= 1'b0;
				end
			end
			if (out_free) begin
				out_valid_q <= busy_q;
			end
		end
	end

	// shifter and output payload
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			shift_q <= pop_data.pattern;
			last_q  <= pop_data.last;
		end else if (load_out) begin
			shift_q <= {shift_q[6:0], 1'b0};
		end
		if (load_out) begin
			out_item_q.serial_bit <= shift_q[7];
			out_item_q.last_bit   <= last_q && (bit_cnt_q == 3'd7);
		end
	end

endmodule
`default_nettype wire

[hw/rtl/seven_segment_number_serializer.sv]
// Seven-segment number serializer, top level: config registers, front end,
// digit queue and bit serializer. Depends on ssns_pkg and the ssns_* modules.
//
// Usage:
//   Input channel (in_valid / in_stall / in_item) takes a request of a 16-bit
//   value and a digit count (0 sends nothing, above 8 is clamped to 8). The
//   value is split least significant digit first in the configured base, each
//   digit is looked up as a segment byte, and the bytes leave on the output
//   channel (out_valid / out_stall / out_item) one bit per result, MSB first,
//   with last_bit set on the final bit of the request.
//   Timing: the divider resolves two quotient bits per cycle; each digit passes
//   through the divide state and then a hand-off state that waits for queue
//   room. A request holds the input stalled until its last digit is queued,
//   and the next one is taken once that digit is queued. The serializer sends
//   one bit per cycle while the receiver does not stall, so output bursts of 8
//   bits are spaced by the divider.
//   Config port (cfg_valid / cfg_ready, always ready): index 0 digit_base,
//   index 1 common_anode; write only while idle. Reset restores base 10 and
//   common-anode mode and empties the queue and output register.
//   When the receiver stalls, the output holds; the queue fills and the
//   front end waits with its digit ready.
`default_nettype none
`include "seven_segment_number_serializer_assert.svh"
module seven_segment_number_serializer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire ssns_pkg::in_item_t   in_item,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output ssns_pkg::out_item_t       out_item,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [3:0]           cfg_index,
	input  wire logic [4:0]           cfg_data
);
	import ssns_pkg::*;

	logic [4:0]    digit_base_q;
	logic          common_anode_q;
	cfg_t          cfg;

	logic          push_valid, push_ready;
	digit_entry_t  push_data;
	logic          pop_valid, pop_ready;
	digit_entry_t  pop_data;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_base_q   <= BASE_RESET;
			common_anode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DIGIT_BASE:   digit_base_q   <= cfg_data;
				REG_COMMON_ANODE: common_anode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg.digit_base   = digit_base_q;
	assign cfg.common_anode = common_anode_q;

	ssns_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_item    (in_item),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	ssns_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	ssns_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_item   (out_item)
	);

	// a request with digits to send keeps the front end busy next cycle
	`SSNS_ASSERT_NEXT(a_req_busy, clk, arst_n, in_valid && !in_stall && in_item.digit_count != 4'd0, in_stall)
	// digits are only handed off while a request is in progress
	`SSNS_ASSERT_SAME(a_push_busy, clk, arst_n, push_valid, in_stall)
	// an empty queue that gets no push stays empty
	`SSNS_ASSERT_NEXT(a_empty_idle, clk, arst_n, !pop_valid && !push_valid && pop_ready, !pop_valid || $past(push_valid))

endmodule
`default_nettype wire

[verif/ssns_checker.sv]
`timescale 1ns / 1ps
// Checker for the seven-segment number serializer: tracks the register writes,
// predicts the serial segment bits of every request and compares them in order.
// Depends on ssns_pkg.
module ssns_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	input  wire logic                in_stall,
	input  wire ssns_pkg::in_item_t  in_item,
	input  wire logic                out_valid,
	input  wire logic                out_stall,
	input  wire ssns_pkg::out_item_t out_item,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [3:0]          cfg_index,
	input  wire logic [4:0]          cfg_data,
	output int                       mismatches,
	output int                       bits_pending
);
	import ssns_pkg::*;

	// common-anode segment bytes, entry 0 in the low byte
	localparam logic [15:0][7:0] SEGMENTS = {
		8'h8E, 8'h86, 8'hA1, 8'hC6, 8'h83, 8'h88, 8'h98, 8'h80,
		8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
	};

	logic [4:0] base_reg  = BASE_RESET;
	logic       anode_reg = 1'b1;
	out_item_t  segment_bits[$];
	out_item_t  want;

	// split the value into digits and queue the eight bits of each segment byte
	function automatic void queue_segment_bits(input in_item_t req);
		logic [4:0]  radix;
		logic [3:0]  ndigits;
		logic [15:0] rest;
		logic [3:0]  digit;
		logic [7:0]  pattern;
		radix = base_reg;
		if (radix < BASE_MIN) radix = BASE_MIN;
		if (radix > BASE_MAX) radix = BASE_MAX;
		ndigits = (req.digit_count > MAX_DIGITS) ? MAX_DIGITS : req.digit_count;
		rest = req.value;
		for (int d = 0; d < ndigits; d++) begin
			digit = 4'(rest % radix);
			// the last digit keeps the remainder only
			if (d + 1 < ndigits) rest = rest / radix;
			pattern = SEGMENTS[digit];
			if (!anode_reg) pattern = ~pattern;
			for (int b = 7; b >= 0; b--) begin
				segment_bits.push_back('{serial_bit: pattern[b],
					last_bit: (d + 1 == ndigits) && (b == 0)});
			end
		end
	endfunction

	task automatic flag_field(input string field, input logic exp_v, input logic act_v);
		mismatches++;
		$display("%0t: %s mismatch, expected %0b, actual %0b", $time, field, exp_v, act_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_reg = BASE_RESET;
			anode_reg = 1'b1;
			segment_bits.delete();
			bits_pending = 0;
		end else begin
			// returned bit against the oldest prediction
			if (out_valid && !out_stall) begin
				if (segment_bits.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected bit, expected none, actual serial %0b last %0b",
						$time, out_item.serial_bit, out_item.last_bit);
				end else begin
					want = segment_bits.pop_front();
					if (want.serial_bit !== out_item.serial_bit)
						flag_field("serial_bit", want.serial_bit, out_item.serial_bit);
					if (want.last_bit !== out_item.last_bit)
						flag_field("last_bit", want.last_bit, out_item.last_bit);
				end
			end
			// a request sees the settings from before a write in the same cycle
			if (in_valid && !in_stall) queue_segment_bits(in_item);
			// register writes; other indexes are ignored
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DIGIT_BASE: base_reg = cfg_data;
					REG_COMMON_ANODE: anode_reg = cfg_data[0];
					default: ;
				endcase
			end
			bits_pending = segment_bits.size();
		end
	end

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Top of the serializer testbench: clock, reset, request and register stimulus,
// output stall pattern, watchdog and verdict. Depends on ssns_pkg and ssns_checker.
module tb_top;
	import ssns_pkg::*;

	localparam int DRAIN_CYCLES = 100;
	localparam int IDLE_LIMIT   = 2000;
	localparam int RAND_PHASES  = 5;
	localparam int PHASE_REQS   = 46;
	// index with no register behind it
	localparam logic [3:0] REG_SPARE = 4'hF;

	logic       clk;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	in_item_t   in_item   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	out_item_t  out_item;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [3:0] cfg_index = '0;
	logic [4:0] cfg_data  = '0;
	int         mismatches;
	int         bits_pending;
	int         burst_left = 0;
	int         idle_cycles = 0;
	int         stall_mode = 0;
	int         mode_left = 0;
	int         run_left = 0;

	seven_segment_number_serializer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ssns_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_item      (in_item),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_item     (out_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.bits_pending (bits_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver: free-running, random, or long stall runs, switching now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 300);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 99) < 35);
				default: begin
					if (run_left == 0) begin
						out_stall <= ~out_stall;
						run_left = $urandom_range(1, 12);
					end else begin
						run_left--;
					end
				end
			endcase
		end
	end

	// watchdog: no handshake on any channel for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// leaves cfg_valid high so back-to-back writes need one assignment per step
	task automatic write_reg(input logic [3:0] idx, input logic [4:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// one request, with a random gap whenever a burst runs out
	task automatic send_req(input logic [15:0] v, input logic [3:0] n);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 10);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item  <= '{value: v, digit_count: n};
		do @(posedge clk); while (in_stall);
	endtask

	// stop sending, wait for every predicted bit, then let trailing work finish
	task automatic drain();
		in_valid <= 1'b0;
		do @(negedge clk); while (bits_pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_mode(input logic [4:0] base, input logic [4:0] anode);
		write_reg(REG_DIGIT_BASE, base);
		write_reg(REG_COMMON_ANODE, anode);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [15:0] v;
		logic [3:0]  n;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: base 10, common anode; zero and clamped counts
		send_req(16'd0, 4'd1);
		send_req(16'hFFFF, 4'd5);
		send_req(16'd12345, 4'd5);
		send_req(16'd9876, 4'd8);
		send_req(16'd1, 4'd0);
		send_req(16'hFFFF, 4'd15);
		send_req(16'h5555, 4'd9);
		drain();

		// hex digits in common-cathode mode
		set_mode(5'd16, 5'd0);
		send_req(16'h0123, 4'd4);
		send_req(16'h4567, 4'd4);
		send_req(16'h89AB, 4'd4);
		send_req(16'hCDEF, 4'd4);
		send_req(16'hFFFF, 4'd8);
		drain();

		set_mode(5'd2, 5'd1);
		send_req(16'hAAAA, 4'd8);
		send_req(16'h5555, 4'd8);
		drain();

		// bases out of range are clamped; only bit 0 of the mode write counts
		set_mode(5'd0, 5'b11110);
		send_req(16'h00F0, 4'd8);
		drain();
		set_mode(5'd31, 5'b00001);
		send_req(16'hBEEF, 4'd4);
		drain();
		set_mode(5'd1, 5'b00000);
		send_req(16'h0F0F, 4'd8);
		drain();
		set_mode(5'd17, 5'b11111);
		write_reg(REG_SPARE, 5'h1E);
		cfg_valid <= 1'b0;
		send_req(16'h1234, 4'd4);
		drain();

		// random phases, each under a random setting
		for (int p = 0; p < RAND_PHASES; p++) begin
			set_mode(($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(2, 16)), 5'($urandom_range(0, 31)));
			for (int i = 0; i < PHASE_REQS; i++) begin
				case ($urandom_range(0, 5))
					0: v = 16'($urandom_range(0, 255));
					1: v = 16'hFFFF - 16'($urandom_range(0, 255));
					default: v = 16'($urandom);
				endcase
				n = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
					: 4'($urandom_range(1, 8));
				send_req(v, n);
			end
			drain();
		end

		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ssns_pkg.sv
hw/rtl/ssns_front.sv
hw/rtl/ssns_queue.sv
hw/rtl/ssns_back.sv
hw/rtl/seven_segment_number_serializer.sv
verif/ssns_checker.sv
verif/tb_top.sv
